// File: design/sir_pkg.sv
// shared types and constants for the segment intersection unit
package sir_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FIELD_W     = 16;
   localparam int NUM_FIELDS  = 8;
   localparam int IN_W        = NUM_FIELDS * FIELD_W;

   localparam int NUM_W       = 51;
   localparam int D_W         = 34;
   localparam int OUT_W       = 2 * NUM_W + D_W;

   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int CROSS_W     = 2 * DIFF_W;
   localparam int XN_W        = COORD_BITS + CROSS_W + 1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int OCC_W       = QCNT_W + 1;

   // classified pair handed from the front to the back
   typedef struct packed {
      logic                        hit;
      logic signed [CROSS_W-1:0]    d;
      logic signed [CROSS_W-1:0]    t;
      logic signed [COORD_BITS-1:0] ax1;
      logic signed [COORD_BITS-1:0] ay1;
      logic signed [DIFF_W-1:0]     a_dx;
      logic signed [DIFF_W-1:0]     a_dy;
   } sir_item_type;

endpackage

// File: design/segment_intersection_rational_unit.sv
// parametric segment intersection with unreduced rational result
// usage:
//   req channel: one beat carries the eight endpoint coordinates of segments a and b
//   rsp channel: one beat per request, in order; tuser is the hit flag, tdata holds
//     the x and y numerators and the shared (sign not normalized) denominator, all
//     zero when there is no hit
// path: the accepting edge loads the first of 4 front stages, then come the queue write,
//   one multiply stage and the result register, which drives rsp_tvalid
// throughput: one beat per cycle while rsp_tready is high; the front is a fixed 4-stage
//   pipe with the six cross products in one stage, the back has the four numerator products
// flow control: the front reserves a slot in the 8-entry queue for every pair it
//   takes, so req_tready drops once 8 pairs sit in the front pipe and the queue
// when rsp_tready is low the result register and back multiply stage hold, the
//   queue fills, and the front keeps accepting until its credit runs out
// reset: synchronous, active high; clears all valid bits and empties the queue, so pairs
//   in flight at reset are dropped and nothing is replayed; no warm-up is needed
// coordinates are taken from the low COORD_BITS of each 16-bit field, sign extended
module segment_intersection_rational_unit import sir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [IN_W-1:0]    req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // x_numerator, y_numerator, shared_denominator
   output logic [OUT_W-1:0]   rsp_tdata,
   // hit
   output logic               rsp_tuser
);

   // front to queue
   logic               push;
   sir_item_type       push_item;

   // queue to back
   logic               pop;
   logic               q_valid;
   sir_item_type       q_item;
   logic [QCNT_W-1:0]  q_count;

   // classification: differences, cross products, bounds check
   sir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_count    (q_count),
      .push       (push),
      .push_item  (push_item)
   );

   // decouples the fixed front pipe from the stallable back
   sir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_count   (q_count)
   );

   // numerator products and result register
   sir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/sir_front.sv
// front pipeline: accepts pairs, forms cross products and classifies the hit
module sir_front import sir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [IN_W-1:0]    req_tdata,
   input  logic [QCNT_W-1:0]  q_count,
   output logic               push,
   output sir_item_type       push_item
);

   logic signed [COORD_BITS-1:0] crd [NUM_FIELDS];
   logic                         accept;
   logic [OCC_W-1:0]             occupancy;

   // stage 1: differences
   logic                         s1_v_ff;
   logic signed [COORD_BITS-1:0] s1_ax1_ff, s1_ay1_ff;
   logic signed [DIFF_W-1:0]     s1_adx_ff, s1_ady_ff, s1_bdx_ff, s1_bdy_ff;
   logic signed [DIFF_W-1:0]     s1_abx_ff, s1_aby_ff;

   // stage 2: products
   logic                         s2_v_ff;
   logic signed [COORD_BITS-1:0] s2_ax1_ff, s2_ay1_ff;
   logic signed [DIFF_W-1:0]     s2_adx_ff, s2_ady_ff;
   logic signed [CROSS_W-1:0]    s2_pd1_ff, s2_pd2_ff, s2_pt1_ff, s2_pt2_ff;
   logic signed [CROSS_W-1:0]    s2_pu1_ff, s2_pu2_ff;

   // stage 3: cross terms
   logic                         s3_v_ff;
   logic signed [COORD_BITS-1:0] s3_ax1_ff, s3_ay1_ff;
   logic signed [DIFF_W-1:0]     s3_adx_ff, s3_ady_ff;
   logic signed [CROSS_W-1:0]    s3_d_ff, s3_t_ff, s3_u_ff;

   // stage 4: classified item
   logic                         s4_v_ff;
   sir_item_type                 s4_item_ff, s4_item_in;

   logic [CROSS_W-1:0] mag_d, mag_t, mag_u;
   logic d_neg, d_zero, t_neg, t_zero, u_neg, u_zero, t_ok, u_ok;

   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         crd[i] = req_tdata[i*FIELD_W +: COORD_BITS];
      end
   end

   // credit check: every pair in flight has a queue slot reserved
   assign occupancy = OCC_W'(q_count) + OCC_W'(s1_v_ff) + OCC_W'(s2_v_ff)
                    + OCC_W'(s3_v_ff) + OCC_W'(s4_v_ff);
   assign req_tready = occupancy < OCC_W'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ax1_ff <= crd[0];
      s1_ay1_ff <= crd[1];
      s1_adx_ff <= DIFF_W'(crd[0]) - DIFF_W'(crd[2]);
      s1_ady_ff <= DIFF_W'(crd[1]) - DIFF_W'(crd[3]);
      s1_bdx_ff <= DIFF_W'(crd[4]) - DIFF_W'(crd[6]);
      s1_bdy_ff <= DIFF_W'(crd[5]) - DIFF_W'(crd[7]);
      s1_abx_ff <= DIFF_W'(crd[0]) - DIFF_W'(crd[4]);
      s1_aby_ff <= DIFF_W'(crd[1]) - DIFF_W'(crd[5]);

      s2_ax1_ff <= s1_ax1_ff;
      s2_ay1_ff <= s1_ay1_ff;
      s2_adx_ff <= s1_adx_ff;
      s2_ady_ff <= s1_ady_ff;
      s2_pd1_ff <= CROSS_W'(s1_adx_ff) * CROSS_W'(s1_bdy_ff);
      s2_pd2_ff <= CROSS_W'(s1_ady_ff) * CROSS_W'(s1_bdx_ff);
      s2_pt1_ff <= CROSS_W'(s1_abx_ff) * CROSS_W'(s1_bdy_ff);
      s2_pt2_ff <= CROSS_W'(s1_aby_ff) * CROSS_W'(s1_bdx_ff);
      s2_pu1_ff <= CROSS_W'(s1_adx_ff) * CROSS_W'(s1_aby_ff);
      s2_pu2_ff <= CROSS_W'(s1_ady_ff) * CROSS_W'(s1_abx_ff);

      s3_ax1_ff <= s2_ax1_ff;
      s3_ay1_ff <= s2_ay1_ff;
      s3_adx_ff <= s2_adx_ff;
      s3_ady_ff <= s2_ady_ff;
      s3_d_ff   <= s2_pd1_ff - s2_pd2_ff;
      s3_t_ff   <= s2_pt1_ff - s2_pt2_ff;
      s3_u_ff   <= s2_pu1_ff - s2_pu2_ff;

      s4_item_ff <= s4_item_in;
   end

   // parametric bounds: t/d in [0,1], -u/d in [0,1)
   always_comb begin
      d_neg  = s3_d_ff[CROSS_W-1];
      t_neg  = s3_t_ff[CROSS_W-1];
      u_neg  = s3_u_ff[CROSS_W-1];
      d_zero = (s3_d_ff == '0);
      t_zero = (s3_t_ff == '0);
      u_zero = (s3_u_ff == '0);
      mag_d  = d_neg ? CROSS_W'(-s3_d_ff) : CROSS_W'(s3_d_ff);
      mag_t  = t_neg ? CROSS_W'(-s3_t_ff) : CROSS_W'(s3_t_ff);
      mag_u  = u_neg ? CROSS_W'(-s3_u_ff) : CROSS_W'(s3_u_ff);
      t_ok   = ((t_neg || t_zero) && d_neg) || (!t_neg && !d_neg && !d_zero);
      u_ok   = ((u_neg || u_zero) && !d_neg && !d_zero) || (!u_neg && d_neg);

      s4_item_in.hit  = !d_zero && t_ok && u_ok && (mag_t <= mag_d) && (mag_u < mag_d);
      s4_item_in.d    = s3_d_ff;
      s4_item_in.t    = s3_t_ff;
      s4_item_in.ax1  = s3_ax1_ff;
      s4_item_in.ay1  = s3_ay1_ff;
      s4_item_in.a_dx = s3_adx_ff;
      s4_item_in.a_dy = s3_ady_ff;
   end

   assign push      = s4_v_ff;
   assign push_item = s4_item_ff;

endmodule

// File: design/sir_queue.sv
// short queue between the front and back pipelines
module sir_queue import sir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sir_item_type       push_item,
   input  logic               pop,
   output logic               q_valid,
   output sir_item_type       q_item,
   output logic [QCNT_W-1:0]  q_count
);

   sir_item_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];
   assign q_count = count_ff;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/sir_back.sv
// back pipeline: intersection numerators and the result register
module sir_back import sir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sir_item_type       q_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [OUT_W-1:0]   rsp_tdata,
   output logic               rsp_tuser
);

   logic                     b1_v_ff;
   logic                     b1_hit_ff;
   logic signed [CROSS_W-1:0] b1_d_ff;
   logic signed [XN_W-1:0]   b1_px_ff, b1_ptx_ff, b1_py_ff, b1_pty_ff;
   logic                     b1_ready, out_ready;

   logic                     rsp_v_ff;
   logic [OUT_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                     rsp_hit_ff;
   logic signed [XN_W-1:0]   xn, yn;

   assign out_ready = !rsp_v_ff || rsp_tready;
   assign b1_ready  = !b1_v_ff || out_ready;
   assign pop       = q_valid && b1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_v_ff <= q_valid;
         end
         if (out_ready) begin
            rsp_v_ff <= b1_v_ff;
         end
      end
   end

   // t*(a_end - a_start) is formed as -(t * a_dx)
   always_ff @(posedge clock) begin
      if (pop) begin
         b1_hit_ff <= q_item.hit;
         b1_d_ff   <= q_item.d;
         b1_px_ff  <= XN_W'($signed(q_item.ax1)) * XN_W'($signed(q_item.d));
         b1_ptx_ff <= XN_W'($signed(q_item.t)) * XN_W'($signed(q_item.a_dx));
         b1_py_ff  <= XN_W'($signed(q_item.ay1)) * XN_W'($signed(q_item.d));
         b1_pty_ff <= XN_W'($signed(q_item.t)) * XN_W'($signed(q_item.a_dy));
      end
   end

   always_comb begin
      xn = b1_px_ff - b1_ptx_ff;
      yn = b1_py_ff - b1_pty_ff;
      if (b1_hit_ff) begin
         rsp_data_in = {D_W'(b1_d_ff), NUM_W'(yn), NUM_W'(xn)};
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && b1_v_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_hit_ff  <= b1_hit_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// File: sim/tb_top.sv
// testbench for the segment intersection unit: directed table plus random pairs, checked beat by beat
`timescale 1ns / 1ps

module tb_top;
   import sir_pkg::*;

   localparam int LATENCY      = 6;
   localparam int SETTLE_CYCLES = 4 * LATENCY;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_PAIRS = 2000;
   localparam int NUM_ROWS     = 19;
   localparam int MAX_GAP      = 20;
   localparam int MAX_BURST    = 40;

   // coordinate slots in the request beat, lowest first
   localparam int AX1 = 0;
   localparam int AY1 = 1;
   localparam int AX2 = 2;
   localparam int AY2 = 3;
   localparam int BX1 = 4;
   localparam int BY1 = 5;
   localparam int BX2 = 6;
   localparam int BY2 = 7;

   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   localparam int CORNER_VALUES [5] = '{-32768, -1, 0, 1, 32767};

   typedef struct packed {
      logic                     hit;
      logic signed [NUM_W-1:0]  x_num;
      logic signed [NUM_W-1:0]  y_num;
      logic signed [D_W-1:0]    den;
   } intersect_result_type;

   typedef struct packed {
      int     ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      bit     typed;
      bit     hit;
      longint x_num, y_num, den;
   } directed_row_type;

   typedef enum int {FULL_RANGE, SMALL_BOX, CROSSING, PARALLEL, CORNERS} pair_shape_type;
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PATTERN} sink_mode_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [IN_W-1:0]  req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [OUT_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   intersect_result_type expected_q [$];
   int error_count = 0;
   int hit_count   = 0;
   int miss_count  = 0;
   int quiet_cycles = 0;
   int burst_left  = 0;
   int sink_hold   = 0;
   sink_mode_type sink_mode = SINK_OPEN;

   // extremes, bounds of both parameters, degenerate and parallel cases
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, TYPED, 1'b0, 0, 0, 0},
      '{0, 0, 10, 0, 0, 5, 10, 5, TYPED, 1'b0, 0, 0, 0},
      '{0, 0, 10, 10, 0, 10, 10, 0, TYPED, 1'b1, -1000, -1000, -200},
      '{0, 10, 10, 0, 0, 0, 10, 10, PREDICTED, 1'b0, 0, 0, 0},
      '{0, 0, 10, 0, 0, -5, 0, 5, PREDICTED, 1'b0, 0, 0, 0},
      '{0, 0, 10, 0, 10, -5, 10, 5, PREDICTED, 1'b0, 0, 0, 0},
      '{-5, 0, 5, 0, 0, 0, 0, 5, PREDICTED, 1'b0, 0, 0, 0},
      '{-5, 0, 5, 0, 0, 5, 0, 0, PREDICTED, 1'b0, 0, 0, 0},
      '{0, 0, 1, 0, 5, -1, 5, 1, PREDICTED, 1'b0, 0, 0, 0},
      '{0, 0, 4, 4, 4, 4, 8, 0, PREDICTED, 1'b0, 0, 0, 0},
      '{3, 3, 3, 3, 0, 0, 6, 6, TYPED, 1'b0, 0, 0, 0},
      '{0, 0, 10, 0, 5, 0, 15, 0, TYPED, 1'b0, 0, 0, 0},
      '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
        PREDICTED, 1'b0, 0, 0, 0},
      '{-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768,
        PREDICTED, 1'b0, 0, 0, 0},
      '{-32768, 0, 32767, 0, 0, -32768, 0, 32767, PREDICTED, 1'b0, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
        TYPED, 1'b0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        TYPED, 1'b0, 0, 0, 0},
      '{21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845,
        PREDICTED, 1'b0, 0, 0, 0},
      '{-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767,
        PREDICTED, 1'b0, 0, 0, 0}
   };

   segment_intersection_rational_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic intersect_result_type predict_intersection(input logic [IN_W-1:0] pair);
      intersect_result_type         res;
      longint                       p [NUM_FIELDS];
      logic signed [COORD_BITS-1:0] raw;
      longint                       den, t_num, u_num, mag_d, mag_t, mag_u;
      logic                         on_a, on_b;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         raw  = pair[i*FIELD_W +: COORD_BITS];
         p[i] = raw;
      end
      den   = (p[AX1] - p[AX2]) * (p[BY1] - p[BY2]) - (p[AY1] - p[AY2]) * (p[BX1] - p[BX2]);
      t_num = (p[AX1] - p[BX1]) * (p[BY1] - p[BY2]) - (p[AY1] - p[BY1]) * (p[BX1] - p[BX2]);
      u_num = (p[AX1] - p[AX2]) * (p[AY1] - p[BY1]) - (p[AY1] - p[AY2]) * (p[AX1] - p[BX1]);
      mag_d = den < 0 ? -den : den;
      mag_t = t_num < 0 ? -t_num : t_num;
      mag_u = u_num < 0 ? -u_num : u_num;
      // t/d within [0,1] on segment a, -u/d within [0,1) on segment b
      on_a = (t_num == 0 || ((t_num < 0) == (den < 0))) && mag_t <= mag_d;
      on_b = (u_num == 0 || ((u_num < 0) != (den < 0))) && mag_u < mag_d;
      res = '0;
      if (den != 0 && on_a && on_b) begin
         res.hit   = 1'b1;
         res.x_num = NUM_W'(p[AX1] * den + t_num * (p[AX2] - p[AX1]));
         res.y_num = NUM_W'(p[AY1] * den + t_num * (p[AY2] - p[AY1]));
         res.den   = D_W'(den);
      end
      return res;
   endfunction

   // source side: bursts of back-to-back beats separated by random gaps
   task automatic offer_pair(input logic [IN_W-1:0] pair, input intersect_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(MAX_BURST, 1);
      end
      expected_q.push_back(want);
      req_tdata  <= pair;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // hold the source off until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // sink side: switches among always ready, coin flip, mostly stalled and a fixed pattern
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(3));
         sink_hold <= $urandom_range(120, 20);
      end else begin
         sink_hold <= sink_hold - 1;
      end
      case (sink_mode)
         SINK_OPEN:    rsp_tready <= 1'b1;
         SINK_COIN:    rsp_tready <= 1'($urandom_range(1));
         SINK_CHOKED:  rsp_tready <= ($urandom_range(7) == 0);
         default:      rsp_tready <= (sink_hold % 4 != 0);
      endcase
   end

   always @(posedge clock) begin : check_results
      intersect_result_type want, got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.hit   = rsp_tuser;
            got.x_num = rsp_tdata[NUM_W-1:0];
            got.y_num = rsp_tdata[2*NUM_W-1:NUM_W];
            got.den   = rsp_tdata[OUT_W-1:2*NUM_W];
            if (got.hit) hit_count++;
            else miss_count++;
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t unexpected result beat: hit=%0b x=%0d y=%0d d=%0d",
                        $time, got.hit, got.x_num, got.y_num, got.den);
            end else begin
               want = expected_q.pop_front();
               if (got.hit !== want.hit || got.x_num !== want.x_num ||
                   got.y_num !== want.y_num || got.den !== want.den) begin
                  error_count++;
                  $display("%0t mismatch: expected hit=%0b x=%0d y=%0d d=%0d",
                           $time, want.hit, want.x_num, want.y_num, want.den);
                  $display("%0t           actual   hit=%0b x=%0d y=%0d d=%0d",
                           $time, got.hit, got.x_num, got.y_num, got.den);
               end
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t timeout: no beat moved for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, expected_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [IN_W-1:0]      pair;
      intersect_result_type want;
      directed_row_type     row;
      pair_shape_type       shape;
      int                   c [NUM_FIELDS];
      int                   mid_x, mid_y, off_x, off_y;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         row  = directed_rows[r];
         pair = {row.by2[FIELD_W-1:0], row.bx2[FIELD_W-1:0],
                 row.by1[FIELD_W-1:0], row.bx1[FIELD_W-1:0],
                 row.ay2[FIELD_W-1:0], row.ax2[FIELD_W-1:0],
                 row.ay1[FIELD_W-1:0], row.ax1[FIELD_W-1:0]};
         if (row.typed) begin
            want.hit   = row.hit;
            want.x_num = row.x_num[NUM_W-1:0];
            want.y_num = row.y_num[NUM_W-1:0];
            want.den   = row.den[D_W-1:0];
         end else begin
            want = predict_intersection(pair);
         end
         offer_pair(pair, want);
      end
      drain_results();

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n == RANDOM_PAIRS / 2) drain_results();
         shape = pair_shape_type'($urandom_range(4));
         case (shape)
            FULL_RANGE: begin
               foreach (c[i]) c[i] = $urandom_range(65535);
            end
            SMALL_BOX: begin
               // tight box: many hits, touches, parallels and repeated points
               foreach (c[i]) c[i] = int'($urandom_range(40)) - 20;
            end
            CROSSING: begin
               // b is centered on a's midpoint so the pair nearly always crosses
               for (int i = AX1; i <= AY2; i++) c[i] = int'($urandom_range(32000)) - 16000;
               mid_x  = (c[AX1] + c[AX2]) / 2;
               mid_y  = (c[AY1] + c[AY2]) / 2;
               off_x  = int'($urandom_range(32000)) - 16000;
               off_y  = int'($urandom_range(32000)) - 16000;
               c[BX1] = mid_x + off_x;
               c[BY1] = mid_y + off_y;
               c[BX2] = mid_x - off_x;
               c[BY2] = mid_y - off_y;
            end
            PARALLEL: begin
               // b is a translated copy of a, zero denominator
               for (int i = AX1; i <= AY2; i++) c[i] = int'($urandom_range(32000)) - 16000;
               off_x  = int'($urandom_range(32000)) - 16000;
               off_y  = int'($urandom_range(32000)) - 16000;
               c[BX1] = c[AX1] + off_x;
               c[BY1] = c[AY1] + off_y;
               c[BX2] = c[AX2] + off_x;
               c[BY2] = c[AY2] + off_y;
            end
            default: begin
               foreach (c[i]) c[i] = CORNER_VALUES[$urandom_range(4)];
            end
         endcase
         foreach (c[i]) pair[i*FIELD_W +: FIELD_W] = c[i][FIELD_W-1:0];
         offer_pair(pair, predict_intersection(pair));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random segment pairs: %0d hits, %0d misses",
               NUM_ROWS, RANDOM_PAIRS, hit_count, miss_count);
      $display("with bursty source, four sink stall modes and two full drains mid-run");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
